>>> hw/rtl/sha256_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-256 hasher package
// Round constants, initial hash values and the controller/datapath interface.
// ---------------------------------------------------------------------------
package sha256_pkg;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef logic [31:0] word_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_byte;   // write wr_data at wr_addr into the block buffer
        logic [5:0] wr_addr;
        logic [7:0] wr_data;
        logic       count_byte;  // advance the message length
        logic       start_comp;  // copy hash state into working variables
        logic       round_en;    // run one compression round
        logic [5:0] round_idx;
        logic       finish_comp; // fold working variables into hash state
        logic       init_hash;   // restore initial hash values and clear length
        logic       len_sel;     // wr_data is taken from the bit length
    } sha_cmd_t;

    function automatic word_t round_k(input logic [5:0] t);
        word_t k;
        case (t)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf; 6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98; 6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic word_t initial_h(input logic [2:0] i);
        word_t h;
        case (i)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

endpackage

>>> hw/rtl/sha256_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-256 datapath
// Block buffer, rolling message schedule, round logic, hash state, length.
// ---------------------------------------------------------------------------
module sha256_datapath
    import sha256_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  sha_cmd_t    cmd,
    input  logic [2:0]  rd_idx,
    output word_t       rd_word
);

    // Block buffer as sixteen big-endian words, each byte lane written alone.
    word_t       buf_reg [16];
    word_t       hash_reg [8];
    word_t       v_reg [8];
    word_t       w_reg [16];
    logic [60:0] count_reg;
    logic [63:0] bits;
    logic [7:0]  wbyte;
    word_t       wt, sched, s0, s1, sum0, sum1, ch, maj, p, q;

    assign bits  = {count_reg, 3'b000};
    assign wbyte = cmd.len_sel ? bits[8*(63 - cmd.wr_addr) +: 8] : cmd.wr_data;

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Rounds 0..15 read the buffer; later rounds use the 16-word window.
    always_comb begin
        s0    = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1    = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        sched = s1 + w_reg[9] + s0 + w_reg[0];
        if (cmd.round_idx[5:4] == 2'b00) begin
            wt = buf_reg[cmd.round_idx[3:0]];
        end else begin
            wt = sched;
        end
        sum1 = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        ch   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        sum0 = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        maj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        p    = v_reg[7] + sum1 + ch + round_k(cmd.round_idx) + wt;
        q    = sum0 + maj;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_byte) begin
            buf_reg[cmd.wr_addr[5:2]][{~cmd.wr_addr[1:0], 3'b000} +: 8] <= wbyte;
        end
        if (cmd.start_comp) begin
            for (int i = 0; i < 8; i++) v_reg[i] <= hash_reg[i];
        end else if (cmd.round_en) begin
            v_reg[0] <= p + q;
            v_reg[1] <= v_reg[0];
            v_reg[2] <= v_reg[1];
            v_reg[3] <= v_reg[2];
            v_reg[4] <= v_reg[3] + p;
            v_reg[5] <= v_reg[4];
            v_reg[6] <= v_reg[5];
            v_reg[7] <= v_reg[6];
            for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
            w_reg[15] <= wt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.init_hash) begin
            for (int i = 0; i < 8; i++) hash_reg[i] <= initial_h(3'(i));
            count_reg <= '0;
        end else begin
            if (cmd.finish_comp) begin
                for (int i = 0; i < 8; i++) hash_reg[i] <= hash_reg[i] + v_reg[i];
            end
            if (cmd.count_byte) begin
                count_reg <= count_reg + 61'd1;
            end
        end
    end

    assign rd_word = hash_reg[rd_idx];

endmodule

>>> hw/rtl/sha256_controller.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte loads, padding, compression rounds and digest output.
// ---------------------------------------------------------------------------
module sha256_controller
    import sha256_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_byte_valid,
    input  logic        s_finish,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_word_index,
    output logic        m_last_word,
    output sha_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_START = 3'd2;
    localparam logic [2:0] ST_ROUND = 3'd3;
    localparam logic [2:0] ST_FOLD  = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [5:0] held_reg, held_next;     // bytes in the buffer
    logic [5:0] ptr_reg, ptr_next;       // pad write position or round index
    logic       fin_reg, fin_next;       // message is ending
    logic       last_blk_reg, last_blk_next; // block being padded has the length
    logic [2:0] out_reg, out_next;
    // A finishing item that filled a block has not started its padding yet.
    logic pad_started_reg, pad_started_next;

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = (state_reg == ST_OUT);
    assign m_word_index = out_reg;
    assign m_last_word  = (out_reg == 3'd7);

    always_comb begin
        state_next    = state_reg;
        held_next     = held_reg;
        ptr_next      = ptr_reg;
        fin_next      = fin_reg;
        last_blk_next = last_blk_reg;
        out_next      = out_reg;
        cmd           = '0;
        cmd.round_idx = ptr_reg;
        cmd.wr_addr   = ptr_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    fin_next = s_finish;
                    if (s_byte_valid) begin
                        cmd.load_byte  = 1'b1;
                        cmd.count_byte = 1'b1;
                        cmd.wr_addr    = held_reg;
                        cmd.wr_data    = s_data_byte;
                        held_next      = held_reg + 6'd1;
                    end
                    if (s_byte_valid && held_reg == 6'd63) begin
                        state_next = ST_START;
                    end else if (s_finish) begin
                        ptr_next   = s_byte_valid ? held_reg + 6'd1 : held_reg;
                        state_next = ST_PAD;
                        last_blk_next = 1'b0;
                    end
                end
            end
            ST_PAD: begin
                // 0x80 at the held count (not in an overflow block), then zeros, then length if it fits.
                cmd.load_byte = 1'b1;
                cmd.wr_data   = (ptr_reg == held_reg && !last_blk_reg) ? PAD_BYTE : 8'h00;
                if (ptr_reg >= 6'd56 && (held_reg < 6'd56 || last_blk_reg)) begin
                    cmd.len_sel = 1'b1;
                end
                ptr_next = ptr_reg + 6'd1;
                if (ptr_reg == 6'd63) begin
                    last_blk_next = (held_reg < 6'd56) || last_blk_reg;
                    state_next    = ST_START;
                end
            end
            ST_START: begin
                cmd.start_comp = 1'b1;
                ptr_next       = 6'd0;
                state_next     = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.round_en = 1'b1;
                ptr_next     = ptr_reg + 6'd1;
                if (ptr_reg == 6'd63) state_next = ST_FOLD;
            end
            ST_FOLD: begin
                cmd.finish_comp = 1'b1;
                if (!fin_reg) begin
                    state_next = ST_IDLE;
                end else if (last_blk_reg) begin
                    out_next   = 3'd0;
                    state_next = ST_OUT;
                end else begin
                    // Full block was just hashed on a finishing item, or the
                    // padding overflowed: write the next padded block.
                    if (held_reg == 6'd0 && !pad_started_reg) begin
                        ptr_next = 6'd0;
                    end else begin
                        held_next     = 6'd0;
                        ptr_next      = 6'd0;
                        last_blk_next = 1'b1;
                    end
                    state_next = ST_PAD;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    out_next = out_reg + 3'd1;
                    if (out_reg == 3'd7) begin
                        cmd.init_hash = 1'b1;
                        held_next     = 6'd0;
                        fin_next      = 1'b0;
                        last_blk_next = 1'b0;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        pad_started_next = pad_started_reg;
        if (state_reg == ST_PAD) pad_started_next = 1'b1;
        if (state_reg == ST_IDLE || state_reg == ST_OUT) pad_started_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            held_reg        <= '0;
            ptr_reg         <= '0;
            fin_reg         <= 1'b0;
            last_blk_reg    <= 1'b0;
            out_reg         <= '0;
            pad_started_reg <= 1'b0;
        end else begin
            state_reg       <= state_next;
            held_reg        <= held_next;
            ptr_reg         <= ptr_next;
            fin_reg         <= fin_next;
            last_blk_reg    <= last_blk_next;
            out_reg         <= out_next;
            pad_started_reg <= pad_started_next;
        end
    end

    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.start_comp && cmd.round_en)) else $error("start and round together");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word_index))
        else $error("digest word dropped");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ROUND |-> !s_ready) else $error("ready during rounds");

endmodule

>>> hw/rtl/sha256_stream_hasher.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-256 stream hasher
// Hashes a byte stream and returns the eight digest words per message.
// ---------------------------------------------------------------------------
// Usage:
//   The input channel (s_valid/s_ready) carries one message byte per
//   transfer with s_byte_valid set; s_finish ends the message after that
//   byte. A transfer with s_byte_valid low and s_finish high ends the
//   message with no byte, so an empty message is allowed.
//   A byte that does not fill the block leaves the input ready. The 64th byte
//   of a block starts compression: a start step, the rounds in turn on
//   the single round unit, then a fold step; no input is taken meanwhile.
//   On finish, padding is written one byte per cycle into the buffer
//   (64 minus the bytes held), followed by a compression; a second
//   padded block and its compression are added when fewer than eight
//   bytes remain after the 0x80 marker.
//   The eight digest words then leave on m_valid/m_ready, H0 first, with
//   m_last_word on the eighth. A stalled receiver holds the current word;
//   no input is taken until the last word transfers.
//   Reset restores the initial hash values and clears the length.
// ---------------------------------------------------------------------------
module sha256_stream_hasher
    import sha256_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_byte_valid,
    input  logic        s_finish,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word
);

    sha_cmd_t cmd;

    sha256_controller u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data_byte, .s_byte_valid,
        .s_finish, .m_valid, .m_ready, .m_word_index, .m_last_word, .cmd
    );

    sha256_datapath u_dp (
        .aclk, .aresetn, .cmd, .rd_idx(m_word_index), .rd_word(m_digest_word)
    );

endmodule

>>> sim/sha256_stream_hasher_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Streams directed and random messages through the hasher, predicts every
// digest with a behavioral SHA-256 kept in step with each accepted transfer,
// and checks each digest word as it leaves, under random idling on both sides.
// ---------------------------------------------------------------------------
module sha256_stream_hasher_test
    import sha256_pkg::*;
;

    // Idling modes of the run, one per phase.
    typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    // One input transfer plus the controls that ride along with it.
    typedef struct {
        logic [7:0] data;
        logic       byte_valid;
        logic       finish;
        idle_mode_t mode;
        bit         wait_drain;  // hold this transfer until all digests are out
        bit         long_hold;   // make the receiver hold off for a long stretch
    } byte_item_t;

    typedef struct {
        word_t      word;
        logic [2:0] index;
        logic       last;
    } digest_word_t;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_CYCLES   = 300;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_byte_valid = 1'b0;
    logic        s_finish = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_digest_word;
    logic [2:0]  m_word_index;
    logic        m_last_word;

    byte_item_t   pending_bytes[$];
    digest_word_t digest_q[$];

    // Behavioral hash state, advanced on each accepted input transfer.
    word_t       hash_words[8];
    logic [7:0]  msg_block[64];
    logic [5:0]  block_fill;
    logic [60:0] msg_len;

    idle_mode_t mode = IDLE_NONE;
    bit         hold_request = 1'b0;
    bit         hold_started = 1'b0;
    int         hold_left = 0;
    int         idle_cycles = 0;
    int         mismatches = 0;
    int         words_checked = 0;
    int         messages_sent = 0;
    int         bytes_sent = 0;

    sha256_stream_hasher dut (.*);

    always #10 aclk = ~aclk;

    function automatic word_t rotr(word_t x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // One SHA-256 compression of msg_block into hash_words.
    function automatic void compress();
        word_t w[64];
        word_t v[8];
        word_t p, q;
        for (int t = 0; t < 16; t++)
            w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
        for (int t = 16; t < 64; t++)
            w[t] = (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
                 + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
        v = hash_words;
        for (int t = 0; t < 64; t++) begin
            p = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
              + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(6'(t)) + w[t];
            q = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
              + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + p;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = p + q;
        end
        for (int i = 0; i < 8; i++) hash_words[i] += v[i];
    endfunction

    function automatic void restart_hash();
        for (int i = 0; i < 8; i++) hash_words[i] = initial_h(3'(i));
        block_fill = '0;
        msg_len = '0;
    endfunction

    // Advances the hash for one accepted transfer; on finish, pads the message
    // and queues the eight digest words it must produce.
    function automatic void hash_byte(logic [7:0] data, logic byte_valid, logic finish);
        logic [63:0] bit_len;
        int at;
        if (byte_valid) begin
            msg_block[block_fill] = data;
            msg_len = msg_len + 1'b1;
            if (block_fill == 6'd63) begin
                compress();
                block_fill = '0;
            end else begin
                block_fill = block_fill + 1'b1;
            end
        end
        if (finish) begin
            bit_len = {msg_len, 3'b000};
            at = int'(block_fill);
            msg_block[at] = PAD_BYTE;
            at++;
            if (at > 56) begin
                while (at < 64) begin msg_block[at] = 8'h00; at++; end
                compress();
                at = 0;
            end
            while (at < 56) begin msg_block[at] = 8'h00; at++; end
            for (int i = 0; i < 8; i++) msg_block[63-i] = bit_len[8*i +: 8];
            compress();
            for (int i = 0; i < 8; i++)
                digest_q.push_back('{hash_words[i], 3'(i), i == 7});
            restart_hash();
            messages_sent++;
        end
    endfunction

    // Driver. It also records each accepted transfer in the predictor, ahead of
    // choosing the next one, so the drain check below sees up-to-date digests.
    always @(posedge aclk) begin
        byte_item_t it;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                hash_byte(s_data_byte, s_byte_valid, s_finish);
                if (s_byte_valid) bytes_sent++;
            end
            if (!s_valid || s_ready) begin
                // A drain marker holds the head transfer back until every digest
                // is out; otherwise the sender idles at random in its phases.
                if (pending_bytes.size() > 0
                        && !(pending_bytes[0].wait_drain && digest_q.size() != 0)
                        && !((mode == IDLE_SEND || mode == IDLE_BOTH)
                             && $urandom_range(99) < (mode == IDLE_SEND ? 55 : 37))) begin
                    it = pending_bytes.pop_front();
                    s_valid      <= 1'b1;
                    s_data_byte  <= it.data;
                    s_byte_valid <= it.byte_valid;
                    s_finish     <= it.finish;
                    mode         <= it.mode;
                    if (it.long_hold) hold_request <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver. A requested long hold is counted here, apart from the driver,
    // which keeps offering transfers until the hasher stops taking them.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_request && !hold_started) begin
            hold_started <= 1'b1;
            hold_left    <= LONG_HOLD;
            m_ready      <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (mode == IDLE_RECV || mode == IDLE_BOTH) begin
            m_ready <= $urandom_range(99) >= (mode == IDLE_RECV ? 55 : 37);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Monitor: every word that leaves is matched with the oldest prediction.
    always @(posedge aclk) begin
        digest_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (digest_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected digest word %h index %0d last %b",
                             m_digest_word, m_word_index, m_last_word);
            end else begin
                want = digest_q.pop_front();
                words_checked++;
                if (m_digest_word !== want.word || m_word_index !== want.index
                        || m_last_word !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: digest word: expected %h/%0d/%b, got %h/%0d/%b",
                                 want.word, want.index, want.last,
                                 m_digest_word, m_word_index, m_last_word);
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither channel completes a transfer.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("sha256_stream_hasher test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic void add_byte(logic [7:0] data, logic byte_valid, logic finish,
                                     idle_mode_t m);
        pending_bytes.push_back('{data, byte_valid, finish, m, 1'b0, 1'b0});
    endfunction

    initial begin
        int         len;
        int         sel;
        bit         drain_done;
        bit         hold_done;
        idle_mode_t m;

        restart_hash();

        // Directed part: an idle transfer, the empty message, "abc" with the
        // finish on its last byte, the byte extremes, and a finish that comes
        // on a transfer without a byte after an idle transfer.
        add_byte(8'h5a, 1'b0, 1'b0, IDLE_NONE);
        add_byte(8'h00, 1'b0, 1'b1, IDLE_NONE);
        add_byte("a", 1'b1, 1'b0, IDLE_NONE);
        add_byte("b", 1'b1, 1'b0, IDLE_NONE);
        add_byte("c", 1'b1, 1'b1, IDLE_NONE);
        add_byte(8'hff, 1'b1, 1'b1, IDLE_NONE);
        add_byte(8'h00, 1'b1, 1'b1, IDLE_NONE);
        add_byte(8'hff, 1'b1, 1'b0, IDLE_NONE);
        add_byte(8'h00, 1'b1, 1'b0, IDLE_NONE);
        add_byte(8'hff, 1'b0, 1'b0, IDLE_NONE);
        add_byte(8'hff, 1'b0, 1'b1, IDLE_NONE);

        // Random messages. Most are short; some sit on the padding boundaries
        // (55/56 bytes) and the block boundaries (63/64/65), a few span blocks.
        drain_done = 1'b0;
        hold_done  = 1'b0;
        while (pending_bytes.size() < 345) begin
            sel = pending_bytes.size();
            m = sel < 100 ? IDLE_NONE : sel < 190 ? IDLE_SEND : sel < 280 ? IDLE_RECV
                : IDLE_BOTH;
            case ($urandom_range(9))
                0:       len = 55 + $urandom_range(1);
                1:       len = 63 + $urandom_range(2);
                2:       len = $urandom_range(66, 130);
                default: len = $urandom_range(12);
            endcase
            // Keep the last message from running far past the item budget.
            if (len > 345 - sel) len = 345 - sel;
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(9) == 0)
                    add_byte(8'($urandom_range(255)), 1'b0, 1'b0, m);
                add_byte(8'($urandom_range(255)), 1'b1,
                         i == len - 1 && $urandom_range(1), m);
            end
            // Close with a byteless finish unless the last byte carried it.
            if (len == 0 || !pending_bytes[$].finish)
                add_byte(8'($urandom_range(255)), 1'b0, 1'b1, m);
            if (m == IDLE_SEND && !drain_done) begin
                add_byte(8'($urandom_range(255)), 1'b1, 1'b0, m);
                pending_bytes[$].wait_drain = 1'b1;
                drain_done = 1'b1;
            end
            if (m == IDLE_RECV && !hold_done) begin
                pending_bytes[$].long_hold = 1'b1;
                hold_done = 1'b1;
            end
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_bytes.size() != 0 || s_valid || digest_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d messages (%0d bytes), %0d digest words checked,",
                 messages_sent, bytes_sent, words_checked);
        $display("across padding and block boundaries under four idling modes.");
        if (mismatches == 0 && digest_q.size() == 0) begin
            $display("sha256_stream_hasher test passed");
        end else begin
            $display("sha256_stream_hasher test failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/sha256_pkg.sv
hw/rtl/sha256_datapath.sv
hw/rtl/sha256_controller.sv
hw/rtl/sha256_stream_hasher.sv
sim/sha256_stream_hasher_test.sv
